// ===== design/tcq_pkg.sv =====
// Package for the timed command queue: shared types, codes and field widths.
// No dependencies; used by every module of the block.
package tcq_pkg;

    localparam int TIME_W = 32;
    localparam int REQ_W  = 31;
    localparam int OBJ_W  = 32;
    localparam int FN_W   = 32;
    localparam int TAG_W  = 16;
    localparam int REM_W  = 7;

    // Command codes carried in the slave-side tuser.
    localparam logic [2:0] OP_SCHED_CMD  = 3'd0;
    localparam logic [2:0] OP_SCHED_FN   = 3'd1;
    localparam logic [2:0] OP_UPDATE     = 3'd2;
    localparam logic [2:0] OP_CANCEL_OBJ = 3'd3;
    localparam logic [2:0] OP_CANCEL_REQ = 3'd4;

    localparam logic [1:0] KIND_REPLY    = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_CANCEL   = 2'd2;
    localparam logic [1:0] KIND_NONE_DUE = 2'd3;

    localparam logic [1:0] DK_FUNCTION = 2'd0;
    localparam logic [1:0] DK_OBJECT   = 2'd1;
    localparam logic [1:0] DK_GLOBAL   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] etime;
        logic [REQ_W-1:0]  request;
        logic [OBJ_W-1:0]  object;
        logic [FN_W-1:0]   func;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    typedef struct packed {
        logic [1:0]       kind;
        logic [REQ_W-1:0] request;
        logic [OBJ_W-1:0] object;
        logic [FN_W-1:0]  func;
        logic [TAG_W-1:0] tag;
        logic [1:0]       dkind;
        logic [1:0]       status;
        logic [REM_W-1:0] removed;
        logic             last;
    } t_result;

    typedef enum logic [1:0] {
        SOP_NONE,
        SOP_INSERT,
        SOP_REMOVE
    } t_store_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_PUT,
        ST_UPD_HEAD,
        ST_UPD_NEXT,
        ST_CAN_SCAN,
        ST_OUT
    } t_state;

endpackage

// ===== design/timed_command_queue.sv =====
// Timed command queue top level: command sequencer, output register and the
// instances of tcq_store and tcq_cmp. Uses tcq_pkg.
//
// Usage. Commands arrive as transactions on the slave side (s_*): tuser holds
// the opcode, tdata the command fields. Results leave as transactions on the
// master side (m_*); tlast marks the final result of a command.
// A schedule command finds its slot by stepping one table entry per cycle
// through the shared comparator from the head, then inserts the entry and
// registers the reply. An update sends one result per dispatched entry and
// waits for the receiver to take each, or a single result when nothing is
// due. A cancel steps one entry per cycle over the whole table. The
// comparator and the single read port of the table set this pace; one
// command is in work at a time and s_tready is low until its last result
// has been taken.
// Unknown opcodes are accepted and give no result.
// Reset (synchronous, active low) empties the table and clears the request
// counter; no clearing pass is needed as entries beyond the count are never
// read. When the receiver holds m_tready low the result stays registered
// and the sequencer waits; nothing is lost or repeated.
module timed_command_queue
    import tcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: current_time[31:0], delay[63:32], object_id[95:64],
    // request_id[126:96], function_hash[158:127], command_tag[174:159],
    // command_present[175], zero fill[183:176].
    input  logic [183:0] s_tdata,
    // tuser: opcode[2:0].
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: out_request[30:0], out_object[62:31],
    // out_function[94:63], out_tag[110:95], status[112:111],
    // removed_count[119:113].
    output logic [119:0] m_tdata,
    // tuser: result_kind[1:0], dispatch_kind[3:2].
    output logic [3:0]   m_tuser,
    output logic         m_tlast
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Command fields as they arrive.
    logic [TIME_W-1:0] in_time;
    logic [TIME_W-1:0] in_delay;
    logic [OBJ_W-1:0]  in_object;
    logic [REQ_W-1:0]  in_request;
    logic [FN_W-1:0]   in_func;
    logic [TAG_W-1:0]  in_tag;
    logic              in_present;

    assign in_time    = s_tdata[31:0];
    assign in_delay   = s_tdata[63:32];
    assign in_object  = s_tdata[95:64];
    assign in_request = s_tdata[126:96];
    assign in_func    = s_tdata[158:127];
    assign in_tag     = s_tdata[174:159];
    assign in_present = s_tdata[175];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_removed, n_removed;
    logic [REQ_W-1:0]  r_req_cnt, n_req_cnt;
    logic [TIME_W-1:0] r_key, n_key;
    logic              r_by_obj, n_by_obj;
    logic              r_more, n_more;
    t_entry            r_new, n_new;
    logic              r_m_valid, n_m_valid;
    t_result           r_res, n_res;

    t_store_op         st_op;
    logic [IW-1:0]     st_idx;
    t_entry            rd_entry;
    t_entry            head_entry;
    logic [TIME_W-1:0] cmp_a;
    logic              cmp_le;
    logic              cmp_eq;
    logic [TIME_W-1:0] eff_delay;

    tcq_store #(
        .DEPTH (QUEUE_DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk    (i_clk),
        .i_op     (st_op),
        .i_idx    (st_idx),
        .i_entry  (r_new),
        .i_rd_idx (r_idx[IW-1:0]),
        .o_rd     (rd_entry),
        .o_head   (head_entry)
    );

    // The one comparator sees the entry time, or the cancel key field.
    always_comb begin
        if (r_state == ST_CAN_SCAN) begin
            cmp_a = r_by_obj ? rd_entry.object : {1'b0, rd_entry.request};
        end else begin
            cmp_a = rd_entry.etime;
        end
    end

    tcq_cmp u_cmp (
        .i_a   (cmp_a),
        .i_key (r_key),
        .o_le  (cmp_le),
        .o_eq  (cmp_eq)
    );

    // A delay that is zero or negative counts as one.
    assign eff_delay = (in_delay == '0 || in_delay[TIME_W-1]) ? TIME_W'(1) : in_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_req_cnt <= '0;
            r_m_valid <= 1'b0;
            r_more    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_req_cnt <= n_req_cnt;
            r_m_valid <= n_m_valid;
            r_more    <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_removed <= n_removed;
        r_key     <= n_key;
        r_by_obj  <= n_by_obj;
        r_new     <= n_new;
        r_res     <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_removed = r_removed;
        n_req_cnt = r_req_cnt;
        n_key     = r_key;
        n_by_obj  = r_by_obj;
        n_more    = r_more;
        n_new     = r_new;
        n_m_valid = r_m_valid;
        n_res     = r_res;
        st_op     = SOP_NONE;
        st_idx    = r_idx[IW-1:0];
        s_tready  = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_res     = '0;
                    n_res.last = 1'b1;
                    n_idx     = '0;
                    n_removed = '0;
                    n_more    = 1'b0;
                    if (s_tuser == OP_SCHED_CMD || s_tuser == OP_SCHED_FN) begin
                        n_req_cnt = r_req_cnt + REQ_W'(1);
                        n_res.kind = KIND_REPLY;
                        if (s_tuser == OP_SCHED_CMD && !in_present) begin
                            n_res.status = STATUS_EMPTY;
                            n_m_valid    = 1'b1;
                            n_state      = ST_OUT;
                        end else if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_res.status = STATUS_FULL;
                            n_m_valid    = 1'b1;
                            n_state      = ST_OUT;
                        end else begin
                            n_key         = in_time + eff_delay;
                            n_new.etime   = in_time + eff_delay;
                            n_new.request = r_req_cnt + REQ_W'(1);
                            n_new.object  = in_object;
                            n_new.func    = (s_tuser == OP_SCHED_FN) ? in_func : '0;
                            n_new.tag     = (s_tuser == OP_SCHED_CMD) ? in_tag : '0;
                            n_state       = ST_INS_SCAN;
                        end
                    end else if (s_tuser == OP_UPDATE) begin
                        n_key   = in_time;
                        n_state = ST_UPD_HEAD;
                    end else if (s_tuser == OP_CANCEL_OBJ || s_tuser == OP_CANCEL_REQ) begin
                        n_by_obj   = (s_tuser == OP_CANCEL_OBJ);
                        n_key      = (s_tuser == OP_CANCEL_OBJ) ? in_object : {1'b0, in_request};
                        n_res.kind = KIND_CANCEL;
                        if (((s_tuser == OP_CANCEL_OBJ) && in_object == '0) ||
                            ((s_tuser == OP_CANCEL_REQ) && in_request == '0)) begin
                            n_m_valid = 1'b1;
                            n_state   = ST_OUT;
                        end else begin
                            n_state = ST_CAN_SCAN;
                        end
                    end
                end
            end
            ST_INS_SCAN: begin
                // Entries with an equal time stay ahead of the new one.
                if (r_idx != r_count && cmp_le) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_state = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                st_op         = SOP_INSERT;
                n_count       = r_count + CW'(1);
                n_res.request = r_new.request;
                n_res.status  = STATUS_OK;
                n_m_valid     = 1'b1;
                n_state       = ST_OUT;
            end
            ST_UPD_HEAD: begin
                if (r_count != '0 && cmp_le) begin
                    n_idx   = CW'(1);
                    n_state = ST_UPD_NEXT;
                end else begin
                    n_res.kind = KIND_NONE_DUE;
                    n_m_valid  = 1'b1;
                    n_state    = ST_OUT;
                end
            end
            ST_UPD_NEXT: begin
                // The head is due; look one entry ahead to set tlast.
                n_res.kind    = KIND_DISPATCH;
                n_res.request = head_entry.request;
                n_res.object  = head_entry.object;
                n_res.func    = head_entry.func;
                n_res.tag     = head_entry.tag;
                if (head_entry.func != '0) begin
                    n_res.dkind = DK_FUNCTION;
                end else if (head_entry.object != '0) begin
                    n_res.dkind = DK_OBJECT;
                end else begin
                    n_res.dkind = DK_GLOBAL;
                end
                n_more     = (r_count > CW'(1)) && cmp_le;
                n_res.last = !n_more;
                st_op      = SOP_REMOVE;
                st_idx     = '0;
                n_count    = r_count - CW'(1);
                n_m_valid  = 1'b1;
                n_state    = ST_OUT;
            end
            ST_CAN_SCAN: begin
                if (r_idx == r_count) begin
                    n_res.removed = REM_W'(r_removed);
                    n_m_valid     = 1'b1;
                    n_state       = ST_OUT;
                end else if (cmp_eq) begin
                    st_op     = SOP_REMOVE;
                    n_count   = r_count - CW'(1);
                    n_removed = r_removed + CW'(1);
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    n_m_valid = 1'b0;
                    n_state   = r_more ? ST_UPD_NEXT : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = r_m_valid;
    assign m_tlast  = r_res.last;
    assign m_tuser  = {r_res.dkind, r_res.kind};
    assign m_tdata  = {r_res.removed, r_res.status, r_res.tag, r_res.func,
                       r_res.object, r_res.request};

endmodule

// ===== design/tcq_cmp.sv =====
// Shared compare unit of the timed command queue: one unsigned 32-bit
// magnitude and equality compare against the current key. Uses tcq_pkg.
module tcq_cmp
    import tcq_pkg::*;
(
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_key,
    output logic              o_le,
    output logic              o_eq
);

    assign o_le = (i_a <= i_key);
    assign o_eq = (i_a == i_key);

endmodule

// ===== design/tcq_store.sv =====
// Entry table of the timed command queue: a register shift line that opens a
// gap to insert at an index or closes one to remove it. Uses tcq_pkg.
module tcq_store
    import tcq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  t_store_op      i_op,
    input  logic [IW-1:0]  i_idx,
    input  t_entry         i_entry,
    input  logic [IW-1:0]  i_rd_idx,
    output t_entry         o_rd,
    output t_entry         o_head
);

    t_entry r_e [DEPTH];

    always_ff @(posedge i_clk) begin
        case (i_op)
            SOP_INSERT: begin
                for (int j = 1; j < DEPTH; j++) begin
                    if (IW'(j) > i_idx) begin
                        r_e[j] <= r_e[j-1];
                    end
                end
                r_e[i_idx] <= i_entry;
            end
            SOP_REMOVE: begin
                for (int j = 0; j < DEPTH - 1; j++) begin
                    if (IW'(j) >= i_idx) begin
                        r_e[j] <= r_e[j+1];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rd   = r_e[i_rd_idx];
    assign o_head = r_e[0];

endmodule

// ===== test/timed_command_queue_checker.sv =====
// Checker for the timed command queue: watches both stream channels, predicts
// every result from accepted commands and compares field by field. Uses tcq_pkg.
module timed_command_queue_checker
    import tcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [183:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    input  logic [3:0]   m_tuser,
    input  logic         m_tlast,
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_entry        table_q[$];
    logic [30:0]   id_counter;
    t_result       due_results[$];

    assign o_pending = due_results.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic t_result blank_result(input logic [1:0] kind);
        t_result r;
        r = '0;
        r.kind = kind;
        r.last = 1'b1;
        return r;
    endfunction

    // Works out the results of one accepted command and updates the table copy.
    task automatic predict_command(input logic [2:0] op, input logic [183:0] d);
        logic [31:0] now, dly, obj, fn, due;
        logic [30:0] req;
        logic [15:0] tag;
        logic        present;
        t_entry      e;
        t_result     r;
        int          pos, removed, n;
        now = d[31:0];
        dly = d[63:32];
        obj = d[95:64];
        req = d[126:96];
        fn = d[158:127];
        tag = d[174:159];
        present = d[175];
        case (op)
            OP_SCHED_CMD, OP_SCHED_FN: begin
                id_counter = id_counter + 31'd1;
                r = blank_result(KIND_REPLY);
                if (op == OP_SCHED_CMD && !present) begin
                    r.status = STATUS_EMPTY;
                end else if (table_q.size() >= QUEUE_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    if (dly == 0 || dly[31]) dly = 32'd1;
                    due = now + dly;
                    pos = 0;
                    while (pos < table_q.size() && table_q[pos].etime <= due) pos++;
                    e.etime = due;
                    e.request = id_counter;
                    e.object = obj;
                    e.func = (op == OP_SCHED_FN) ? fn : '0;
                    e.tag = (op == OP_SCHED_CMD) ? tag : '0;
                    table_q.insert(pos, e);
                    r.request = id_counter;
                end
                due_results.push_back(r);
            end
            OP_UPDATE: begin
                n = 0;
                while (table_q.size() > 0 && table_q[0].etime <= now) begin
                    e = table_q.pop_front();
                    r = '0;
                    r.kind = KIND_DISPATCH;
                    r.request = e.request;
                    r.object = e.object;
                    r.func = e.func;
                    r.tag = e.tag;
                    r.dkind = (e.func != 0) ? DK_FUNCTION :
                              (e.object != 0) ? DK_OBJECT : DK_GLOBAL;
                    due_results.push_back(r);
                    n++;
                end
                if (n == 0) due_results.push_back(blank_result(KIND_NONE_DUE));
                else due_results[$].last = 1'b1;
            end
            OP_CANCEL_OBJ, OP_CANCEL_REQ: begin
                removed = 0;
                if ((op == OP_CANCEL_OBJ && obj != 0) || (op == OP_CANCEL_REQ && req != 0)) begin
                    pos = 0;
                    while (pos < table_q.size()) begin
                        if ((op == OP_CANCEL_OBJ && table_q[pos].object == obj) ||
                            (op == OP_CANCEL_REQ && table_q[pos].request == req)) begin
                            table_q.delete(pos);
                            removed++;
                        end else begin
                            pos++;
                        end
                    end
                end
                r = blank_result(KIND_CANCEL);
                r.removed = removed[6:0];
                due_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic compare_result();
        t_result x, g;
        g = '0;
        g.request = m_tdata[30:0];
        g.object = m_tdata[62:31];
        g.func = m_tdata[94:63];
        g.tag = m_tdata[110:95];
        g.status = m_tdata[112:111];
        g.removed = m_tdata[119:113];
        g.kind = m_tuser[1:0];
        g.dkind = m_tuser[3:2];
        g.last = m_tlast;
        if (due_results.size() == 0) begin
            report_mismatch("result with nothing expected");
        end else begin
            x = due_results.pop_front();
            if (g !== x) report_mismatch($sformatf("got %h expected %h", g, x));
        end
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            table_q.delete();
            due_results.delete();
            id_counter = '0;
        end else begin
            // The result side is checked first so a command accepted in the
            // same cycle cannot matter (the block takes one at a time anyway).
            if (m_tvalid && m_tready) compare_result();
            if (s_tvalid && s_tready) predict_command(s_tuser, s_tdata);
        end
    end
endmodule

// ===== test/timed_command_queue_test.sv =====
// Testbench top for the timed command queue: clock, reset, command stimulus,
// receiver stalls and the verdict. Depends on tcq_pkg and the checker module.
module timed_command_queue_test;
    import tcq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int RANDOM_ITEMS = 290;
    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;
    int           errors;
    int           pending;
    int           cycles = 0;
    bit           quiet_phase = 1'b0;
    bit           hold_off = 1'b0;
    // Recent request ids and objects, so that cancels usually hit something.
    logic [30:0]  id_seen = '0;
    logic [31:0]  obj_pool[4] = '{32'd0, 32'd5, 32'd77, 32'hFFFF_FFFF};
    logic [31:0]  sim_now = 32'd1000;

    timed_command_queue #(.QUEUE_DEPTH(DEPTH)) dut (.*);

    timed_command_queue_checker #(.QUEUE_DEPTH(DEPTH)) checker_inst (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a run that stops making progress fails here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, none in the quiet phase, a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else m_tready <= !hold_off && (quiet_phase || $urandom_range(99) >= 16);
    end

    // Drives one command transaction and waits until it is accepted.
    task automatic send_command(input logic [2:0] op, input logic [31:0] now,
                                input logic [31:0] dly, input logic [31:0] obj,
                                input logic [30:0] req, input logic [31:0] fn,
                                input logic [15:0] tag, input logic present);
        while (!quiet_phase && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {8'd0, present, tag, fn, req, obj, dly, now};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (op == OP_SCHED_CMD || op == OP_SCHED_FN) id_seen = id_seen + 31'd1;
    endtask

    task automatic send_random();
        logic [2:0]  op;
        logic [31:0] dly, obj;
        logic [30:0] req;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30) op = OP_SCHED_CMD;
        else if (pick < 55) op = OP_SCHED_FN;
        else if (pick < 80) op = OP_UPDATE;
        else if (pick < 88) op = OP_CANCEL_OBJ;
        else if (pick < 96) op = OP_CANCEL_REQ;
        else op = 3'($urandom_range(5, 7));
        sim_now = sim_now + $urandom_range(0, 40);
        // Mostly short positive delays; sometimes zero, negative or huge.
        case ($urandom_range(9))
            0: dly = 32'd0;
            1: dly = 32'h8000_0000 | $urandom;
            2: dly = $urandom;
            default: dly = $urandom_range(1, 60);
        endcase
        obj = ($urandom_range(3) == 0) ? $urandom : obj_pool[$urandom_range(3)];
        req = ($urandom_range(3) == 0) ? 31'($urandom) :
              id_seen - 31'($urandom_range(0, 6));
        send_command(op, ($urandom_range(19) == 0) ? $urandom : sim_now, dly, obj,
                     req, ($urandom_range(2) == 0) ? 32'd0 : $urandom,
                     16'($urandom), $urandom_range(9) != 0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed part: empty update, rejection, extremes, time wrap, equal
        // times, every dispatch kind, filling the table, and the cancels.
        send_command(OP_UPDATE, 32'd0, 0, 0, 0, 0, 0, 0);
        send_command(OP_SCHED_CMD, 32'd10, 32'd5, 32'd9, 0, 0, 16'hFFFF, 1'b0);
        send_command(OP_SCHED_CMD, 32'd10, 32'd5, 32'd9, 0, 0, 16'hFFFF, 1'b1);
        send_command(OP_SCHED_CMD, 32'd10, 32'd5, 32'd0, 0, 0, 16'h0001, 1'b1);
        send_command(OP_SCHED_FN, 32'd10, 32'd5, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                     32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_command(OP_SCHED_FN, 32'd10, 32'd5, 32'd3, 0, 32'd0, 0, 1'b0);
        send_command(OP_SCHED_FN, 32'd10, 32'h8000_0000, 32'd4, 0, 32'd7, 0, 1'b1);
        send_command(OP_SCHED_FN, 32'd10, 32'd0, 32'd4, 0, 32'd8, 0, 1'b1);
        send_command(OP_SCHED_CMD, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'd6, 0, 0,
                     16'h1234, 1'b1);
        send_command(OP_UPDATE, 32'd15, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < DEPTH + 2; i++)
            send_command(i[0] ? OP_SCHED_FN : OP_SCHED_CMD, 32'd100, 32'd3,
                         32'd77, 0, 32'd1, 16'd2, 1'b1);
        send_command(OP_CANCEL_OBJ, 0, 0, 32'd0, 0, 0, 0, 0);
        send_command(OP_CANCEL_REQ, 0, 0, 32'd77, 31'd0, 0, 0, 0);
        send_command(OP_CANCEL_REQ, 0, 0, 0, id_seen - 31'd3, 0, 0, 0);
        send_command(OP_CANCEL_OBJ, 0, 0, 32'd77, 0, 0, 0, 0);
        send_command(3'd7, 0, 0, 0, 0, 0, 0, 0);
        send_command(OP_UPDATE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        // Back pressure: the receiver holds off while commands keep coming.
        hold_off = 1'b1;
        fork
            repeat (300) @(posedge i_clk);
            repeat (8) send_random();
        join_any
        hold_off = 1'b0;
        wait fork;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet_phase = (i >= 150 && i < 200);
            send_random();
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
